// File: rtl/edt_pkg.sv
// ----------------------------------------------------------------------------
// edt_pkg
// Shared types and constants of the elapsed day timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edt_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int MASK_W  = 4;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TIME = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_LGT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_WTR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_NUT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD_FLAG = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_LIMIT   = 1'd1;

    // Reset values and bounds
    localparam logic [WORD_W-1:0] TICK_PERIOD_RST = 16'd500;
    localparam logic [BYTE_W-1:0] DAY_LIMIT_RST   = 8'd15;
    localparam logic [BYTE_W-1:0] SEC_BOUND       = 8'd59;
    localparam logic [BYTE_W-1:0] MIN_BOUND       = 8'd59;
    localparam logic [BYTE_W-1:0] HOUR_BOUND      = 8'd23;
    localparam logic [BYTE_W-1:0] FLAG_SECOND     = 8'h80;
    localparam logic [WORD_W-1:0] LIGHT_RST       = 16'd1;
    localparam logic [WORD_W-1:0] WATER_RST       = 16'd1;
    localparam logic [WORD_W-1:0] NUT_RST         = 16'd0;

    // Control into one cascade cell
    typedef struct packed {
        logic load;
        logic adv;
    } t_cell_ctl;

    // Status out of one cascade cell
    typedef struct packed {
        logic carry;
        logic wr;
    } t_cell_sts;

endpackage

// File: rtl/edt_if.sv
// ----------------------------------------------------------------------------
// edt_if
// Valid/ready channels of the elapsed day timer: command, result, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface edt_in_if;
    logic                          valid;
    logic                          ready;
    logic [edt_pkg::CMD_W-1:0]     cmd;
    logic [edt_pkg::WORD_W-1:0]    load_value;

    modport source (output valid, output cmd, output load_value, input ready);
    modport sink   (input valid, input cmd, input load_value, output ready);
endinterface

interface edt_out_if;
    logic                          valid;
    logic                          ready;
    logic [edt_pkg::BYTE_W-1:0]    second_flag;
    logic [edt_pkg::WORD_W-1:0]    light_elapsed;
    logic [edt_pkg::WORD_W-1:0]    water_elapsed;
    logic [edt_pkg::WORD_W-1:0]    nutrition_elapsed;
    logic [edt_pkg::BYTE_W-1:0]    seconds_now;
    logic [edt_pkg::BYTE_W-1:0]    minutes_now;
    logic [edt_pkg::BYTE_W-1:0]    hours_now;
    logic [edt_pkg::BYTE_W-1:0]    day_now;
    logic [edt_pkg::MASK_W-1:0]    persist_mask;

    modport source (output valid, output second_flag, output light_elapsed,
                    output water_elapsed, output nutrition_elapsed,
                    output seconds_now, output minutes_now, output hours_now,
                    output day_now, output persist_mask, input ready);
    modport sink   (input valid, input second_flag, input light_elapsed,
                    input water_elapsed, input nutrition_elapsed,
                    input seconds_now, input minutes_now, input hours_now,
                    input day_now, input persist_mask, output ready);
endinterface

interface edt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [edt_pkg::CFG_IDX_W-1:0] index;
    logic [edt_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/edt_cell.sv
// ----------------------------------------------------------------------------
// edt_cell
// One cell of the seconds/minutes/hours/day cascade: holds one field,
// advances on a carry from its lower neighbour and passes a carry upward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edt_cell #(
    parameter bit HOLD_AT_BOUND = 1'b0   // 1: hold at bound, 0: wrap to zero
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  edt_pkg::t_cell_ctl            i_ctl,
    input  logic [edt_pkg::BYTE_W-1:0]    i_bound,
    input  logic [edt_pkg::BYTE_W-1:0]    i_load_val,
    output logic [edt_pkg::BYTE_W-1:0]    o_next,
    output edt_pkg::t_cell_sts            o_sts
);

    logic [edt_pkg::BYTE_W-1:0] r_val;
    logic [edt_pkg::BYTE_W-1:0] n_val;
    logic                       below;

    assign below = (r_val < i_bound);

    // Next field value and carry
    always_comb begin
        n_val       = r_val;
        o_sts.carry = 1'b0;
        o_sts.wr    = 1'b0;
        if (i_ctl.load) begin
            n_val    = i_load_val;
            o_sts.wr = 1'b1;
        end else if (i_ctl.adv) begin
            if (below) begin
                n_val    = r_val + 1'b1;
                o_sts.wr = 1'b1;
            end else if (!HOLD_AT_BOUND) begin
                n_val       = '0;
                o_sts.wr    = 1'b1;
                o_sts.carry = 1'b1;
            end
        end
    end

    assign o_next = n_val;

    // Hold the field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= n_val;
        end
    end

endmodule

// File: rtl/edt_elapsed.sv
// ----------------------------------------------------------------------------
// edt_elapsed
// Elapsed-seconds counter: counts while nonzero, wraps to zero and stops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edt_elapsed (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [edt_pkg::WORD_W-1:0] i_init,
    input  logic                       i_load,
    input  logic [edt_pkg::WORD_W-1:0] i_load_val,
    input  logic                       i_bump,
    output logic [edt_pkg::WORD_W-1:0] o_next
);

    logic [edt_pkg::WORD_W-1:0] r_cnt;
    logic [edt_pkg::WORD_W-1:0] n_cnt;

    // Load, or advance a running count
    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_load_val;
        end else if (i_bump && (r_cnt != '0)) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_next = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= i_init;
        end else if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/elapsed_day_timer.sv
// ----------------------------------------------------------------------------
// elapsed_day_timer
// Prescaled seconds/minutes/hours/day timer with three elapsed counters.
// ----------------------------------------------------------------------------
// Each command transfer yields one result transfer, registered in the output
// register. A command is taken in every cycle in which the output register
// is empty or its result is being taken, so the block sustains one item per
// clock; the whole update (prescaler, cascade of four cells and elapsed
// counters) is combinational. tick_period of zero acts as one.
// Configuration writes are always ready and should be issued only while
// no result is pending.
`timescale 1ns / 1ps

module elapsed_day_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    edt_in_if.sink     i_in,
    edt_out_if.source  o_out,
    edt_cfg_if.sink    i_cfg
);

    localparam int WW = edt_pkg::WORD_W;
    localparam int BW = edt_pkg::BYTE_W;

    logic [WW-1:0] r_tick_period;
    logic [BW-1:0] r_day_limit;
    logic [WW-1:0] r_tick_count;
    logic [WW-1:0] n_tick_count;
    logic [BW-1:0] r_flag;
    logic [BW-1:0] n_flag;

    logic          accept;
    logic          is_tick;
    logic [WW:0]   tick_inc;
    logic [WW:0]   period;
    logic          second;

    edt_pkg::t_cell_ctl sec_ctl, min_ctl, hour_ctl, day_ctl;
    edt_pkg::t_cell_sts sec_sts, min_sts, hour_sts, day_sts;
    logic [BW-1:0] sec_next, min_next, hour_next, day_next;
    logic [WW-1:0] light_next, water_next, nut_next;
    logic          ld_time;

    logic          r_out_valid;
    logic [BW-1:0] r_flag_out;
    logic [WW-1:0] r_light_out, r_water_out, r_nut_out;
    logic [BW-1:0] r_sec_out, r_min_out, r_hour_out, r_day_out;
    logic [edt_pkg::MASK_W-1:0] r_mask_out;

    // Handshakes
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= edt_pkg::TICK_PERIOD_RST;
            r_day_limit   <= edt_pkg::DAY_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                edt_pkg::CFG_TICK_PERIOD: r_tick_period <= i_cfg.data;
                edt_pkg::CFG_DAY_LIMIT:   r_day_limit   <= i_cfg.data[BW-1:0];
                default: ;
            endcase
        end
    end

    // Prescaler
    assign is_tick  = (i_in.cmd == edt_pkg::CMD_TICK);
    assign tick_inc = {1'b0, r_tick_count} + 1'b1;
    assign period   = (r_tick_period == '0) ? (WW+1)'(1) : {1'b0, r_tick_period};
    assign second   = is_tick && (tick_inc >= period);

    always_comb begin
        n_tick_count = r_tick_count;
        if (is_tick) begin
            n_tick_count = second ? '0 : tick_inc[WW-1:0];
        end
    end

    // Second flag
    always_comb begin
        n_flag = r_flag;
        if (second) begin
            n_flag = edt_pkg::FLAG_SECOND;
        end else if (i_in.cmd == edt_pkg::CMD_LOAD_FLAG) begin
            n_flag = i_in.load_value[BW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_flag       <= '0;
        end else if (accept) begin
            r_tick_count <= n_tick_count;
            r_flag       <= n_flag;
        end
    end

    // Cascade of time cells, carry passed upward
    assign ld_time       = (i_in.cmd == edt_pkg::CMD_LOAD_TIME);
    assign sec_ctl.load  = ld_time;
    assign sec_ctl.adv   = second;
    assign min_ctl.load  = ld_time;
    assign min_ctl.adv   = sec_sts.carry;
    assign hour_ctl.load = ld_time;
    assign hour_ctl.adv  = min_sts.carry;
    assign day_ctl.load  = ld_time;
    assign day_ctl.adv   = hour_sts.carry;

    edt_cell #(.HOLD_AT_BOUND(1'b0)) u_sec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_ctl(sec_ctl),
        .i_bound(edt_pkg::SEC_BOUND), .i_load_val(i_in.load_value[BW-1:0]),
        .o_next(sec_next), .o_sts(sec_sts)
    );

    edt_cell #(.HOLD_AT_BOUND(1'b0)) u_min (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_ctl(min_ctl),
        .i_bound(edt_pkg::MIN_BOUND), .i_load_val(i_in.load_value[BW-1:0]),
        .o_next(min_next), .o_sts(min_sts)
    );

    edt_cell #(.HOLD_AT_BOUND(1'b0)) u_hour (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_ctl(hour_ctl),
        .i_bound(edt_pkg::HOUR_BOUND), .i_load_val(i_in.load_value[BW-1:0]),
        .o_next(hour_next), .o_sts(hour_sts)
    );

    edt_cell #(.HOLD_AT_BOUND(1'b1)) u_day (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_ctl(day_ctl),
        .i_bound(r_day_limit), .i_load_val(i_in.load_value[BW-1:0]),
        .o_next(day_next), .o_sts(day_sts)
    );

    // Elapsed counters
    edt_elapsed u_light (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_init(edt_pkg::LIGHT_RST),
        .i_load(i_in.cmd == edt_pkg::CMD_LOAD_LGT), .i_load_val(i_in.load_value),
        .i_bump(second), .o_next(light_next)
    );

    edt_elapsed u_water (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_init(edt_pkg::WATER_RST),
        .i_load(i_in.cmd == edt_pkg::CMD_LOAD_WTR), .i_load_val(i_in.load_value),
        .i_bump(second), .o_next(water_next)
    );

    edt_elapsed u_nut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_init(edt_pkg::NUT_RST),
        .i_load(i_in.cmd == edt_pkg::CMD_LOAD_NUT),
        .i_load_val({{(WW-BW){1'b0}}, i_in.load_value[BW-1:0]}),
        .i_bump(second), .o_next(nut_next)
    );

    // Output register: valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flag_out  <= n_flag;
            r_light_out <= light_next;
            r_water_out <= water_next;
            r_nut_out   <= nut_next;
            r_sec_out   <= sec_next;
            r_min_out   <= min_next;
            r_hour_out  <= hour_next;
            r_day_out   <= day_next;
            r_mask_out  <= {day_sts.wr, hour_sts.wr, min_sts.wr, sec_sts.wr};
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.second_flag       = r_flag_out;
    assign o_out.light_elapsed     = r_light_out;
    assign o_out.water_elapsed     = r_water_out;
    assign o_out.nutrition_elapsed = r_nut_out;
    assign o_out.seconds_now       = r_sec_out;
    assign o_out.minutes_now       = r_min_out;
    assign o_out.hours_now         = r_hour_out;
    assign o_out.day_now           = r_day_out;
    assign o_out.persist_mask      = r_mask_out;

    // A pending result that is not taken blocks new commands
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("command accepted while result stalled");

    // A minute write always comes with a seconds write
    a_mask_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_mask_out[1] || r_mask_out[0]))
        else $error("minute write without seconds write");

    // A day and time load reports all four fields
    a_load_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ld_time) |=> (r_out_valid && (r_mask_out == 4'hF)))
        else $error("time load did not report full mask");

endmodule
